>>> src/tun_pkg.sv
package tun_pkg;

  localparam int CW = 12;
  localparam int OW = 16;

  typedef struct packed {
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic signed [CW-1:0] c_x;
    logic signed [CW-1:0] c_y;
    logic signed [CW-1:0] c_z;
  } tun_in_t;

  typedef struct packed {
    logic signed [OW-1:0] norm_x;
    logic signed [OW-1:0] norm_y;
    logic signed [OW-1:0] norm_z;
    logic                 degenerate;
  } tun_out_t;

endpackage

>>> src/tun_cell.sv
module tun_cell #(
  parameter int SW  = 56,
  parameter int QW  = 15,
  parameter int AW  = 88,
  parameter int PW  = 74,
  parameter int BIT = 0
) (
  input  logic                 clk,
  input  logic                 adv,
  input  logic [SW-1:0]        s_i,
  input  logic [SW-1:0]        r_i [3],
  input  logic [2:0]           g_i,
  input  logic [QW-1:0]        q_i [3],
  input  logic [AW-1:0]        a_i [3],
  input  logic signed [PW-1:0] p_i [3],
  output logic [SW-1:0]        s_o,
  output logic [SW-1:0]        r_o [3],
  output logic [2:0]           g_o,
  output logic [QW-1:0]        q_o [3],
  output logic [AW-1:0]        a_o [3],
  output logic signed [PW-1:0] p_o [3]
);
  // One bit of a restoring search: try setting bit BIT in each quotient.
  // a holds (2q-1)^2 * s and p holds (2q-1) * s, so a trial is shifts and adds.
  localparam int XW = AW + 2;
  localparam int RS = 2 * QW;

  logic [QW-1:0]        q_nxt [3];
  logic [AW-1:0]        a_nxt [3];
  logic signed [PW-1:0] p_nxt [3];
  logic [QW-1:0]        q_r [3];
  logic [AW-1:0]        a_r [3];
  logic signed [PW-1:0] p_r [3];
  logic [SW-1:0]        r_r [3];
  logic [SW-1:0]        s_r;
  logic [2:0]           g_r;

  always_comb begin
    logic [XW-1:0] trial;
    logic [XW-1:0] bound;
    for (int i = 0; i < 3; i++) begin
      trial = XW'(a_i[i]) + (XW'(p_i[i]) << (BIT + 2)) + (XW'(s_i) << (2 * BIT + 2));
      bound = XW'(r_i[i]) << RS;
      if (trial <= bound) begin
        q_nxt[i] = q_i[i] | (QW'(1) << BIT);
        a_nxt[i] = AW'(trial);
        p_nxt[i] = p_i[i] + (PW'(s_i) << (BIT + 1));
      end else begin
        q_nxt[i] = q_i[i];
        a_nxt[i] = a_i[i];
        p_nxt[i] = p_i[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_r <= q_nxt;
      a_r <= a_nxt;
      p_r <= p_nxt;
      r_r <= r_i;
      s_r <= s_i;
      g_r <= g_i;
    end
  end

  assign q_o = q_r;
  assign a_o = a_r;
  assign p_o = p_r;
  assign r_o = r_r;
  assign s_o = s_r;
  assign g_o = g_r;
endmodule

>>> src/triangle_unit_normal_top.sv
// Unit face normal of a streamed triangle. A triangle can enter every cycle while
// the pipeline is not held. Registered stages form edges, products, cross product,
// magnitudes, squares and squared length, then a row of FRAC_BITS+1 cells fixes
// one quotient bit each, and an output register applies signs. A low out_ready
// while out_valid is high holds the whole pipeline and drops in_ready with it. A
// degenerate triangle gives zero components and the degenerate flag.
module triangle_unit_normal_top #(
  parameter int FRAC_BITS = 14
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tun_pkg::tun_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output tun_pkg::tun_out_t out_data
);
  import tun_pkg::*;

  localparam int EW = CW + 1;
  localparam int MW = 2 * EW + 1;
  localparam int SW = 2 * MW + 2;
  localparam int QW = FRAC_BITS + 1;
  localparam int NC = QW;
  localparam int AW = 2 * QW + 2 + SW;
  localparam int PW = QW + 3 + SW;
  localparam int NW = QW + OW;
  localparam int DEPTH = NC + 7;

  logic adv;
  logic [DEPTH-1:0] v_r;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;
  assign out_valid = v_r[DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[DEPTH-2:0], in_valid};
    end
  end

  logic signed [EW-1:0] e_r [6];
  logic signed [CW-1:0] ax, ay, az;
  assign ax = in_data.a_x;
  assign ay = in_data.a_y;
  assign az = in_data.a_z;

  logic signed [2*EW-1:0] p_r [6];
  logic signed [MW-1:0]   n_r [3];
  logic [MW-1:0]          m_r [3];
  logic [2:0]             sg_r;
  logic [2*MW-1:0]        sq_r [3];
  logic [2:0]             sq_sg_r;
  logic [SW-1:0]          s0_r;
  logic [SW-1:0]          r0_r [3];
  logic [2:0]             g0_r;
  logic signed [PW-1:0]   p0_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      e_r[0] <= EW'(in_data.b_x) - EW'(ax);
      e_r[1] <= EW'(in_data.b_y) - EW'(ay);
      e_r[2] <= EW'(in_data.b_z) - EW'(az);
      e_r[3] <= EW'(in_data.c_x) - EW'(ax);
      e_r[4] <= EW'(in_data.c_y) - EW'(ay);
      e_r[5] <= EW'(in_data.c_z) - EW'(az);
      p_r[0] <= (2*EW)'(e_r[4]) * (2*EW)'(e_r[2]);
      p_r[1] <= (2*EW)'(e_r[5]) * (2*EW)'(e_r[1]);
      p_r[2] <= (2*EW)'(e_r[5]) * (2*EW)'(e_r[0]);
      p_r[3] <= (2*EW)'(e_r[3]) * (2*EW)'(e_r[2]);
      p_r[4] <= (2*EW)'(e_r[3]) * (2*EW)'(e_r[1]);
      p_r[5] <= (2*EW)'(e_r[4]) * (2*EW)'(e_r[0]);
      for (int i = 0; i < 3; i++) begin
        n_r[i] <= MW'(p_r[2*i]) - MW'(p_r[2*i+1]);
        m_r[i] <= n_r[i][MW-1] ? MW'(-n_r[i]) : MW'(n_r[i]);
        sg_r[i] <= n_r[i][MW-1];
        sq_r[i] <= (2*MW)'(m_r[i]) * (2*MW)'(m_r[i]);
        r0_r[i] <= SW'(sq_r[i]);
      end
      sq_sg_r <= sg_r;
      s0_r <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
      p0_r <= -(PW'(sq_r[0]) + PW'(sq_r[1]) + PW'(sq_r[2]));
      g0_r <= sq_sg_r;
    end
  end

  logic [SW-1:0]        cs [NC+1];
  logic [SW-1:0]        cr [NC+1][3];
  logic [2:0]           cg [NC+1];
  logic [QW-1:0]        cq [NC+1][3];
  logic [AW-1:0]        ca [NC+1][3];
  logic signed [PW-1:0] cp [NC+1][3];

  assign cs[0] = s0_r;
  assign cr[0] = r0_r;
  assign cg[0] = g0_r;
  assign cq[0] = '{QW'(0), QW'(0), QW'(0)};
  assign ca[0] = '{AW'(s0_r), AW'(s0_r), AW'(s0_r)};
  assign cp[0] = '{p0_r, p0_r, p0_r};

  for (genvar k = 0; k < NC; k++) begin : g_cell
    tun_cell #(.SW(SW), .QW(QW), .AW(AW), .PW(PW), .BIT(QW - 1 - k)) u_cell (
      .clk(clk), .adv(adv),
      .s_i(cs[k]), .r_i(cr[k]), .g_i(cg[k]), .q_i(cq[k]), .a_i(ca[k]), .p_i(cp[k]),
      .s_o(cs[k+1]), .r_o(cr[k+1]), .g_o(cg[k+1]), .q_o(cq[k+1]), .a_o(ca[k+1]),
      .p_o(cp[k+1])
    );
  end

  tun_out_t      o_r;
  logic [OW-1:0] nv [3];
  logic          deg;
  assign deg = (cs[NC] == '0);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nv[i] = cg[NC][i] ? OW'(-NW'(cq[NC][i])) : OW'(NW'(cq[NC][i]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_r.degenerate <= deg;
      o_r.norm_x <= deg ? '0 : nv[0];
      o_r.norm_y <= deg ? '0 : nv[1];
      o_r.norm_z <= deg ? '0 : nv[2];
    end
  end
  assign out_data = o_r;

`ifndef SYNTH
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("word dropped under stall");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready) else $error("ready lost");
  a_deg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |-> out_data.norm_x == '0
      && out_data.norm_y == '0 && out_data.norm_z == '0)
    else $error("degenerate word not zero");
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("word after reset");
`endif
endmodule
